[src/pwe_pkg.sv]
`default_nettype none
package pwe_pkg;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_REF = 3'd1,
    ST_BAD_VCO = 3'd2,
    ST_BAD_RES = 3'd3,
    ST_BAD_CUR = 3'd4,
    ST_BAD_OD  = 3'd5
  } status_e;

  localparam int unsigned CurEntries = 20;

  localparam logic [11:0] CurVal [CurEntries] = '{
    12'd125,  12'd250,  12'd375,  12'd500,  12'd625,
    12'd750,  12'd875,  12'd1000, 12'd1125, 12'd1250,
    12'd1500, 12'd1750, 12'd1875, 12'd2000, 12'd2250,
    12'd2500, 12'd2625, 12'd3000, 12'd3500, 12'd4000
  };

  // Byte 11 bits 5..3 for each current entry
  localparam logic [2:0] CurB11 [CurEntries] = '{
    3'd7, 3'd7, 3'd7, 3'd7, 3'd3, 3'd2, 3'd1, 3'd0, 3'd5, 3'd3,
    3'd5, 3'd1, 3'd3, 3'd0, 3'd2, 3'd3, 3'd1, 3'd0, 3'd1, 3'd0
  };

  localparam logic [CurEntries-1:0] CurB15 = 20'b1100_1010_1110_0000_1010;
  localparam logic [CurEntries-1:0] CurB16 = 20'b1111_1101_0101_0000_1100;

  localparam logic [15:0] Ohms64k = 16'd64000;
  localparam logic [15:0] Ohms52k = 16'd52000;
  localparam logic [15:0] Ohms16k = 16'd16000;
  localparam logic [15:0] Ohms4k  = 16'd4000;

  localparam logic [11:0] RefMax = 12'd2055;
  localparam logic [11:0] VcoMin = 12'd12;
  localparam logic [13:0] OdMax  = 14'd8232;
  localparam logic [13:0] OdFixedMax = 14'd37;
  localparam logic [13:0] FacMMin = 14'd6;
  localparam logic [13:0] FacMMax = 14'd1029;

  typedef struct packed {
    logic       hit;
    logic [2:0] b11;
    logic       b15;
    logic       b16;
  } cur_code_t;

  // Stage 1 result: decoded fields and first failing check
  typedef struct packed {
    status_e     status;
    logic [15:0] ref_bits;
    logic [15:0] vco_bits;
    logic [1:0]  res_bits;
    logic [2:0]  cur_b11;
    logic        cur_b15;
    logic        cur_b16;
    logic [13:0] out_div;
  } dec_t;

  // Stage 2 result: output divider encoded
  typedef struct packed {
    status_e     status;
    logic [15:0] ref_bits;
    logic [15:0] vco_bits;
    logic [1:0]  res_bits;
    logic [2:0]  cur_b11;
    logic        cur_b15;
    logic        cur_b16;
    logic        od_b11;
    logic [7:0]  od_b12;
    logic [5:0]  od_b13;
  } enc_t;

  typedef struct packed {
    status_e      status;
    logic [159:0] word;
  } res_t;

  function automatic cur_code_t cur_lookup(logic [11:0] cur);
    cur_code_t c;
    c = '0;
    for (int k = 0; k < CurEntries; k++) begin
      if (CurVal[k] == cur) begin
        c.hit = 1'b1;
        c.b11 = CurB11[k];
        c.b15 = CurB15[k];
        c.b16 = CurB16[k];
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[src/pll_program_word_encode_top.sv]
// PLL programming word encoder.
// Slave stream: one word of synthesizer settings per handshake. The encoder
// checks every field and builds the 160-bit programming word from a fixed
// base pattern, or returns a zero word with an error status.
// Master stream: one result word for each accepted settings word, in order.
// Pipeline: three register stages (field decode and checks, output divider
// factoring, word assembly); each settings word passes through all three in
// that order before its result is offered on the master side. Throughput is
// one word per cycle while the receiver takes results. Each stage holds its
// word while the next one is full and stalled; s_axis_tready drops only when
// all three stages are full and m_axis_tready is low, so nothing is lost or
// repeated across a stall.
// Reset (rst_ni low, asynchronous) empties the pipeline; no state lives
// between words, so no settling time follows reset.
`default_nettype none
module pll_program_word_encode_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // [11:0] ref_div, [23:12] vco_div, [39:24] filter_ohms,
  // [51:40] pump_current, [65:52] out_div, [71:66] zero
  input  wire logic [71:0]   s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // [63:0] word_low, [127:64] word_mid, [159:128] word_high,
  // [162:160] status, [167:163] zero
  output logic [167:0]       m_axis_tdata
);

  logic           v1, r1, v2, r2;
  pwe_pkg::dec_t  dec;
  pwe_pkg::enc_t  enc;
  pwe_pkg::res_t  res;

  // Stage 1: range checks, reference/VCO fields, resistor and current tables
  pwe_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .ref_div_i      (s_axis_tdata[11:0]),
    .vco_div_i      (s_axis_tdata[23:12]),
    .filter_ohms_i  (s_axis_tdata[39:24]),
    .pump_current_i (s_axis_tdata[51:40]),
    .out_div_i      (s_axis_tdata[65:52]),
    .valid_o        (v1),
    .ready_i        (r1),
    .dec_o          (dec)
  );

  // Stage 2: output divider codes and factoring
  pwe_odiv u_odiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r1),
    .dec_i   (dec),
    .valid_o (v2),
    .ready_i (r2),
    .enc_o   (enc)
  );

  // Stage 3: merge into the base pattern; this register feeds the master side
  pwe_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r2),
    .enc_i   (enc),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {5'b00000, res.status, res.word};

endmodule
`default_nettype wire

[src/pwe_check.sv]
`default_nettype none
module pwe_check (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire logic [11:0]   ref_div_i,
  input  wire logic [11:0]   vco_div_i,
  input  wire logic [15:0]   filter_ohms_i,
  input  wire logic [11:0]   pump_current_i,
  input  wire logic [13:0]   out_div_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output pwe_pkg::dec_t      dec_o
);

  logic                valid_q;
  pwe_pkg::dec_t       dec_d, dec_q;
  pwe_pkg::cur_code_t  cur;
  logic [11:0]         ref_m2, ref_m8, vco_m8;
  logic                ref_ok, vco_ok, res_ok, od_ok;
  logic [1:0]          res_bits;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    ref_m2 = ref_div_i - 12'd2;
    ref_m8 = ref_div_i - 12'd8;
    vco_m8 = vco_div_i - 12'd8;
    ref_ok = (ref_div_i != 12'd0) && (ref_div_i <= pwe_pkg::RefMax);
    vco_ok = (vco_div_i >= pwe_pkg::VcoMin) && (vco_div_i <= pwe_pkg::RefMax);
    od_ok  = (out_div_i >= 14'd2) && (out_div_i <= pwe_pkg::OdMax);
    cur    = pwe_pkg::cur_lookup(pump_current_i);

    res_ok = 1'b1;
    if (filter_ohms_i == pwe_pkg::Ohms64k) begin
      res_bits = 2'b00;
    end else if (filter_ohms_i == pwe_pkg::Ohms52k) begin
      res_bits = 2'b10;
    end else if (filter_ohms_i == pwe_pkg::Ohms16k) begin
      res_bits = 2'b01;
    end else if (filter_ohms_i == pwe_pkg::Ohms4k) begin
      res_bits = 2'b11;
    end else begin
      res_bits = 2'b00;
      res_ok   = 1'b0;
    end

    dec_d = '0;
    if (ref_div_i == 12'd1) begin
      dec_d.ref_bits = 16'h0000;
    end else if (ref_div_i == 12'd2) begin
      dec_d.ref_bits = 16'h0001;
    end else if (ref_div_i <= 12'd17) begin
      dec_d.ref_bits = {8'h00, 2'b00, ~ref_m2[3:0], 2'b10};
    end else begin
      dec_d.ref_bits = {2'b00, ref_m8, 2'b11};
    end
    dec_d.vco_bits = {vco_m8[10:0], 5'b00000};
    dec_d.res_bits = res_bits;
    dec_d.cur_b11  = cur.b11;
    dec_d.cur_b15  = cur.b15;
    dec_d.cur_b16  = cur.b16;
    dec_d.out_div  = out_div_i;

    // first failing check wins
    if (!ref_ok) begin
      dec_d.status = pwe_pkg::ST_BAD_REF;
    end else if (!vco_ok) begin
      dec_d.status = pwe_pkg::ST_BAD_VCO;
    end else if (!res_ok) begin
      dec_d.status = pwe_pkg::ST_BAD_RES;
    end else if (!cur.hit) begin
      dec_d.status = pwe_pkg::ST_BAD_CUR;
    end else if (!od_ok) begin
      dec_d.status = pwe_pkg::ST_BAD_OD;
    end else begin
      dec_d.status = pwe_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule
`default_nettype wire

[src/pwe_odiv.sv]
`default_nettype none
module pwe_odiv (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire pwe_pkg::dec_t dec_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output pwe_pkg::enc_t      enc_o
);

  logic           valid_q;
  pwe_pkg::enc_t  enc_d, enc_q;
  logic [13:0]    od;
  logic [13:0]    m_cand, m_sel, m_m6, od_m6;
  logic [1:0]     z_sel;
  logic           fac_hit;
  logic [8:0]     fac_i;

  assign ready_o = !valid_q || ready_i;
  assign od      = dec_i.out_div;

  // Factor as m * 2^z with m in 6..1029; the largest z gives the smallest i
  always_comb begin
    fac_hit = 1'b0;
    z_sel   = 2'd0;
    m_sel   = 14'd0;
    m_cand  = 14'd0;
    for (int k = 0; k < 4; k++) begin
      m_cand = od >> k;
      if (((od & ((14'd1 << k) - 14'd1)) == 14'd0) &&
          (m_cand >= pwe_pkg::FacMMin) && (m_cand <= pwe_pkg::FacMMax)) begin
        fac_hit = 1'b1;
        z_sel   = 2'(k);
        m_sel   = m_cand;
      end
    end
    m_m6  = m_sel - pwe_pkg::FacMMin;
    fac_i = m_m6[9:1];
    od_m6 = od - 14'd6;
  end

  always_comb begin
    enc_d.status   = dec_i.status;
    enc_d.ref_bits = dec_i.ref_bits;
    enc_d.vco_bits = dec_i.vco_bits;
    enc_d.res_bits = dec_i.res_bits;
    enc_d.cur_b11  = dec_i.cur_b11;
    enc_d.cur_b15  = dec_i.cur_b15;
    enc_d.cur_b16  = dec_i.cur_b16;
    enc_d.od_b11   = 1'b0;
    enc_d.od_b12   = 8'h00;
    enc_d.od_b13   = 6'd0;
    case (od)
      14'd2:  ;
      14'd3:  enc_d.od_b11 = 1'b1;
      14'd4:  enc_d.od_b12 = 8'h04;
      14'd5:  enc_d.od_b12 = 8'h01;
      14'd6:  begin enc_d.od_b11 = 1'b1; enc_d.od_b12 = 8'h04; end
      14'd7:  begin enc_d.od_b11 = 1'b1; enc_d.od_b12 = 8'h01; end
      14'd9:  begin enc_d.od_b11 = 1'b1; enc_d.od_b12 = 8'h05; end
      14'd11: begin enc_d.od_b11 = 1'b1; enc_d.od_b12 = 8'h09; end
      14'd13: begin enc_d.od_b11 = 1'b1; enc_d.od_b12 = 8'h0d; end
      default: begin
        if (od <= pwe_pkg::OdFixedMax) begin
          enc_d.od_b12 = {1'b0, ~od_m6[4:0], 2'b10};
        end else begin
          enc_d.od_b11 = 1'b1;
          if (fac_hit) begin
            enc_d.od_b12 = {fac_i[2:0], z_sel, ~m_sel[0], 2'b10};
            enc_d.od_b13 = fac_i[8:3];
          end else begin
            enc_d.od_b12 = 8'h02;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      enc_q <= enc_d;
    end
  end

  assign valid_o = valid_q;
  assign enc_o   = enc_q;

endmodule
`default_nettype wire

[src/pwe_pack.sv]
`default_nettype none
module pwe_pack (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire pwe_pkg::enc_t enc_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output pwe_pkg::res_t      res_o
);

  logic           valid_q;
  pwe_pkg::res_t  res_d, res_q;
  logic [159:0]   w;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    w = '0;
    w[15:0]    = enc_i.ref_bits;
    w[23:8]    = w[23:8] | enc_i.vco_bits;
    w[95:88]   = {enc_i.od_b11, 1'b0, enc_i.cur_b11, enc_i.res_bits, 1'b0};
    w[103:96]  = enc_i.od_b12;
    w[111:104] = {2'b01, enc_i.od_b13};
    w[119:112] = 8'h01;
    w[127:120] = {enc_i.cur_b15, 7'b0000100};
    w[135:128] = {7'b0000000, enc_i.cur_b16};
    w[159:136] = 24'hffffff;

    res_d.status = enc_i.status;
    // drop the word on any error
    res_d.word   = (enc_i.status == pwe_pkg::ST_OK) ? w : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

[test/pwe_tb_pkg.sv]
`default_nettype none
package pwe_tb_pkg;

  typedef struct packed {
    logic [13:0] out_div;
    logic [11:0] pump_current;
    logic [15:0] filter_ohms;
    logic [11:0] vco_div;
    logic [11:0] ref_div;
  } settings_t;

  typedef struct {
    logic [63:0]      word_low;
    logic [63:0]      word_mid;
    logic [31:0]      word_high;
    pwe_pkg::status_e status;
  } program_word_t;

  class pll_word_scoreboard;
    program_word_t pending_words[$];
    int unsigned   mismatches;
    int unsigned   words_checked;

    function new();
      mismatches    = 0;
      words_checked = 0;
    endfunction

    // Build the 160-bit programming word byte by byte from one settings word.
    function automatic program_word_t predict_program_word(settings_t s);
      logic [11:0] pump_steps [20] = '{
        12'd125, 12'd250, 12'd375, 12'd500, 12'd625, 12'd750, 12'd875,
        12'd1000, 12'd1125, 12'd1250, 12'd1500, 12'd1750, 12'd1875,
        12'd2000, 12'd2250, 12'd2500, 12'd2625, 12'd3000, 12'd3500, 12'd4000
      };
      logic [7:0] pump_byte11 [20] = '{
        8'h38, 8'h38, 8'h38, 8'h38, 8'h18, 8'h10, 8'h08, 8'h00, 8'h28, 8'h18,
        8'h28, 8'h08, 8'h18, 8'h00, 8'h10, 8'h18, 8'h08, 8'h00, 8'h08, 8'h00
      };
      logic [19:0] pump_byte15 = 20'b1100_1010_1110_0000_1010;
      logic [19:0] pump_byte16 = 20'b1111_1101_0101_0000_1100;
      logic [7:0]       b [20];
      logic [31:0]      t;
      pwe_pkg::status_e st;
      int               sel;
      bit               hit;
      program_word_t    w;
      foreach (b[n]) b[n] = 8'h00;
      b[19] = 8'hff; b[18] = 8'hff; b[17] = 8'hff;
      b[15] = 8'h04; b[14] = 8'h01; b[13] = 8'h40;
      st = pwe_pkg::ST_OK;

      // reference divider: four encodings by range
      if (s.ref_div == 12'd1) begin
      end else if (s.ref_div == 12'd2) begin
        b[0] = 8'h01;
      end else if (s.ref_div >= 12'd3 && s.ref_div <= 12'd17) begin
        t = (~(32'(s.ref_div) - 32'd2)) << 2;
        b[0] = (t[7:0] & 8'h3e) | 8'h02;
      end else if (s.ref_div >= 12'd18 && s.ref_div <= 12'd2055) begin
        t = ((32'(s.ref_div) - 32'd8) << 2) | 32'd3;
        b[0] = t[7:0];
        b[1] = t[15:8];
      end else begin
        st = pwe_pkg::ST_BAD_REF;
      end

      if (st == pwe_pkg::ST_OK) begin
        if (s.vco_div >= 12'd12 && s.vco_div <= 12'd2055) begin
          t = (32'(s.vco_div) - 32'd8) << 5;
          b[1] |= t[7:0];
          b[2] |= t[15:8];
        end else begin
          st = pwe_pkg::ST_BAD_VCO;
        end
      end

      if (st == pwe_pkg::ST_OK) begin
        case (s.filter_ohms)
          16'd64000: ;
          16'd52000: b[11] |= 8'h04;
          16'd16000: b[11] |= 8'h02;
          16'd4000:  b[11] |= 8'h06;
          default:   st = pwe_pkg::ST_BAD_RES;
        endcase
      end

      if (st == pwe_pkg::ST_OK) begin
        sel = -1;
        for (int k = 0; k < 20; k++)
          if (sel < 0 && pump_steps[k] == s.pump_current) sel = k;
        if (sel < 0) begin
          st = pwe_pkg::ST_BAD_CUR;
        end else begin
          b[11] |= pump_byte11[sel];
          if (pump_byte15[sel]) b[15] |= 8'h80;
          if (pump_byte16[sel]) b[16] |= 8'h01;
        end
      end

      if (st == pwe_pkg::ST_OK) begin
        if (s.out_div < 14'd2 || s.out_div > 14'd8232) begin
          st = pwe_pkg::ST_BAD_OD;
        end else begin
          case (s.out_div)
            14'd2:  ;
            14'd3:  b[11] |= 8'h80;
            14'd4:  b[12] = 8'h04;
            14'd5:  b[12] = 8'h01;
            14'd6:  begin b[11] |= 8'h80; b[12] = 8'h04; end
            14'd7:  begin b[11] |= 8'h80; b[12] = 8'h01; end
            14'd9:  begin b[11] |= 8'h80; b[12] = 8'h05; end
            14'd11: begin b[11] |= 8'h80; b[12] = 8'h09; end
            14'd13: begin b[11] |= 8'h80; b[12] = 8'h0d; end
            default: begin
              if (s.out_div <= 14'd37) begin
                t = (~(32'(s.out_div) - 32'd6)) << 2;
                b[12] = (t[7:0] & 8'h7c) | 8'h02;
              end else begin
                // smallest i first, then y = 0 before y = 1, z ascending
                hit = 1'b0;
                for (int i = 0; i < 512 && !hit; i++)
                  for (int y = 0; y < 2 && !hit; y++)
                    for (int z = 0; z < 4 && !hit; z++)
                      if (int'(s.out_div) == ((2 * (i + 3) + y) << z)) begin
                        t = 32'(i) << 5;
                        b[12] |= t[7:0];
                        b[13] |= t[15:8] & 8'h3f;
                        b[12] |= 8'(z << 3) | (y != 0 ? 8'h00 : 8'h04);
                        hit = 1'b1;
                      end
                b[11] |= 8'h80;
                b[12] |= 8'h02;
              end
            end
          endcase
        end
      end

      w.status = st;
      for (int k = 0; k < 8; k++) begin
        w.word_low[8*k +: 8] = (st == pwe_pkg::ST_OK) ? b[k] : 8'h00;
        w.word_mid[8*k +: 8] = (st == pwe_pkg::ST_OK) ? b[8+k] : 8'h00;
      end
      for (int k = 0; k < 4; k++)
        w.word_high[8*k +: 8] = (st == pwe_pkg::ST_OK) ? b[16+k] : 8'h00;
      return w;
    endfunction

    function void note_settings(settings_t s);
      pending_words.push_back(predict_program_word(s));
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      $display("word %0d: %s mismatch, got %h want %h", words_checked, field, got, want);
      mismatches++;
    endtask

    task check_word(logic [167:0] d);
      program_word_t want;
      if (pending_words.size() == 0) begin
        report("unexpected word", d[63:0], 64'h0);
      end else begin
        want = pending_words.pop_front();
        if (d[63:0] !== want.word_low) report("word_low", d[63:0], want.word_low);
        if (d[127:64] !== want.word_mid) report("word_mid", d[127:64], want.word_mid);
        if (d[159:128] !== want.word_high)
          report("word_high", 64'(d[159:128]), 64'(want.word_high));
        if (d[162:160] !== want.status)
          report("status", 64'(d[162:160]), 64'(want.status));
      end
      words_checked++;
    endtask
  endclass

endpackage
`default_nettype wire

[test/tb.sv]
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // [11:0] ref_div, [23:12] vco_div, [39:24] filter_ohms,
  // [51:40] pump_current, [65:52] out_div, [71:66] zero
  logic [71:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [63:0] word_low, [127:64] word_mid, [159:128] word_high,
  // [162:160] status, [167:163] zero
  logic [167:0] m_axis_tdata;

  // Percent of cycles in which the sender idles or the receiver stalls.
  int unsigned idle_pct;
  int unsigned stall_pct;

  pwe_tb_pkg::pll_word_scoreboard sb = new();

  pll_program_word_encode_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: roll a stall decision every falling edge.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare every accepted result word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  function automatic pwe_tb_pkg::settings_t mk(int r, int v, int o, int c, int d);
    pwe_tb_pkg::settings_t s;
    s.ref_div      = 12'(r);
    s.vco_div      = 12'(v);
    s.filter_ohms  = 16'(o);
    s.pump_current = 12'(c);
    s.out_div      = 14'(d);
    return s;
  endfunction

  // Mostly legal fields so most words get through every check; the rest
  // are out of range or off-table to hit each error status.
  function automatic pwe_tb_pkg::settings_t random_settings();
    pwe_tb_pkg::settings_t s;
    case ($urandom_range(9))
      0:       s.ref_div = 12'($urandom_range(2));
      1:       s.ref_div = 12'($urandom_range(17, 3));
      2:       s.ref_div = 12'($urandom_range(2055, 2040));
      3:       s.ref_div = 12'($urandom);
      default: s.ref_div = 12'($urandom_range(2055, 18));
    endcase
    case ($urandom_range(9))
      0:       s.vco_div = 12'($urandom_range(15, 8));
      1:       s.vco_div = 12'($urandom_range(2055, 2040));
      2:       s.vco_div = 12'($urandom);
      default: s.vco_div = 12'($urandom_range(2055, 12));
    endcase
    case ($urandom_range(11))
      0:       s.filter_ohms = 16'($urandom);
      1, 2:    s.filter_ohms = pwe_pkg::Ohms52k;
      3, 4:    s.filter_ohms = pwe_pkg::Ohms16k;
      5, 6:    s.filter_ohms = pwe_pkg::Ohms4k;
      default: s.filter_ohms = pwe_pkg::Ohms64k;
    endcase
    if ($urandom_range(9) == 0) s.pump_current = 12'($urandom);
    else s.pump_current = pwe_pkg::CurVal[$urandom_range(pwe_pkg::CurEntries - 1)];
    case ($urandom_range(9))
      0:          s.out_div = 14'($urandom);
      1, 2, 3:    s.out_div = 14'($urandom_range(37, 2));
      4, 5:       s.out_div = 14'($urandom_range(300, 38));
      6:          s.out_div = 14'($urandom_range(8232, 8180));
      default:    s.out_div = 14'($urandom_range(8232, 38));
    endcase
    return s;
  endfunction

  // Offer one settings word, idling first at the current rate; return at
  // the falling edge after the handshake.
  task automatic send_settings(pwe_tb_pkg::settings_t s);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'd0, s};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_settings(s);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned idle_plan  [4];
    int unsigned stall_plan [4];
    idle_plan     = '{0, 61, 0, 20};
    stall_plan    = '{0, 0, 61, 20};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words: field extremes, every ref encoding, each error status,
    // check order with several bad fields, fixed and factored output dividers.
    send_settings(mk(1, 300, 64000, 125, 2));
    send_settings(mk(2, 300, 64000, 125, 2));
    send_settings(mk(3, 300, 64000, 125, 2));
    send_settings(mk(17, 300, 64000, 125, 2));
    send_settings(mk(2055, 2055, 64000, 125, 2));
    send_settings(mk(0, 0, 0, 0, 0));                  // all bad: ref wins
    send_settings(mk(2056, 300, 64000, 125, 2));
    send_settings(mk(4095, 4095, 65535, 4095, 16383)); // all ones: ref wins
    send_settings(mk(40, 11, 1, 0, 0));                // vco before resistor
    send_settings(mk(40, 12, 64000, 125, 2));
    send_settings(mk(40, 300, 52000, 250, 4));
    send_settings(mk(40, 300, 16000, 375, 5));
    send_settings(mk(40, 300, 4000, 4000, 6));
    send_settings(mk(40, 300, 1, 3999, 0));            // resistor before current
    send_settings(mk(40, 300, 64000, 3999, 16383));    // current before divider
    send_settings(mk(40, 300, 64000, 125, 1));
    send_settings(mk(40, 300, 64000, 125, 8233));
    send_settings(mk(40, 300, 64000, 3000, 3));
    send_settings(mk(40, 300, 64000, 2625, 13));
    send_settings(mk(40, 300, 64000, 1875, 37));
    send_settings(mk(40, 300, 64000, 1125, 38));
    send_settings(mk(40, 300, 64000, 1500, 8232));
    send_settings(mk(40, 300, 64000, 2500, 8231));     // no factorization
    send_settings(mk(40, 300, 64000, 2250, 9));
    send_settings(mk(40, 300, 64000, 3500, 8));

    // Random words across four handshake pressure phases.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_plan[phase];
      stall_pct = stall_plan[phase];
      repeat (108) send_settings(random_settings());
    end
    s_axis_tvalid = 1'b0;
    idle_pct      = 0;

    // Drain the pipeline, then hold a few cycles for any stray word.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("pll_program_word_encode_top regression: pass");
    end else begin
      $display("pll_program_word_encode_top regression: fail");
    end
    $finish;
  end

  // Bound the run well past the slowest legal drain.
  initial begin
    #2_000_000;
    $display("pll_program_word_encode_top regression: fail");
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
src/pwe_pkg.sv
src/pwe_check.sv
src/pwe_odiv.sv
src/pwe_pack.sv
src/pll_program_word_encode_top.sv
test/pwe_tb_pkg.sv
test/tb.sv
